// ===== rtl/slr_pkg.sv =====
`default_nettype none

package slr_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int HOLD_W     = 16;
   localparam int MS_W       = 32;
   localparam int PLACE_W    = 11;

   localparam logic [HOLD_W-1:0] HOLD_LIMIT_RESET = 16'd4000;

   // register word index on the csr port
   localparam logic REG_HOLD_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_BTN_ONE = 2'd1,
      OP_BTN_TWO = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_RESET   = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_STOPPED = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       button_one_level;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [MS_W-1:0]    elapsed_ms;
      logic [PLACE_W-1:0] shown_place;
      logic [MS_W-1:0]    shown_lap_ms;
      logic               view_changed;
      logic               laps_full;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/slr_lap_mem.sv =====
`default_nettype none

module slr_lap_mem #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/stopwatch_lap_recorder_unit.sv =====
`default_nettype none

// channel   direction  ports                       word
// req       in         req_valid / req_ready       req_word (opcode, button_one_level)
// rsp       out        rsp_valid / rsp_ready       rsp_word (mode .. laps_full)
// csr       in/out     csr_psel .. csr_pready      hold_limit_ticks at byte address 0
//
// for an item, the accept edge updates the state registers and issues at most
// one lap memory access (write of a new lap or read of the shown lap); the edge
// on which the read stage moves loads the output register from the memory read
// data, forwarded lap or zero. a word is accepted only when the read stage is empty.
// reset is synchronous; the lap memory is not cleared, only laps below the
// current position are ever read. a stalled output holds the read stage.

module stopwatch_lap_recorder_unit #(
   parameter int LAP_DEPTH  = 1024,
   parameter int TIME_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  slr_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output slr_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [slr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [slr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [slr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import slr_pkg::*;

   localparam int IDX_W = $clog2(LAP_DEPTH);
   localparam int POS_W = $clog2(LAP_DEPTH + 1);
   localparam logic [POS_W-1:0] POS_FULL = POS_W'(LAP_DEPTH);
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_FWD
   } lap_src_type;

   // state registers
   mode_type              mode_ff, mode_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      last_ff, last_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic [HOLD_W-1:0]     hold_limit_ff;

   // read stage
   logic                  s1_valid_ff;
   lap_src_type           s1_src_ff, src_in;
   logic [TIME_WIDTH-1:0] s1_lap_ff;
   mode_type              s1_mode_ff;
   logic [TIME_WIDTH-1:0] s1_elapsed_ff;
   logic [POS_W-1:0]      s1_pos_ff;
   logic                  s1_changed_ff, changed_in;
   logic                  s1_full_ff, full_in;

   // output register
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   logic                  accept;
   logic                  move;
   logic                  wr_en;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [TIME_WIDTH-1:0] rd_data;
   logic [HOLD_W:0]       hold_next;
   logic [MS_W-1:0]       shown_ms;
   logic                  csr_write;

   assign req_ready = !s1_valid_ff;
   assign accept    = req_valid && req_ready;
   assign move      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign hold_next = {1'b0, hold_ff} + {{HOLD_W{1'b0}}, 1'b1};

   always_comb begin
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      hold_in    = hold_ff;
      changed_in = 1'b0;
      full_in    = 1'b0;
      wr_en      = 1'b0;
      if (accept) begin
         case (req_word.opcode)
            OP_TICK: begin
               hold_in = '0;
               if (mode_ff == MODE_RUNNING) begin
                  elapsed_in = elapsed_ff + TIME_WIDTH'(1);
               end else if (mode_ff == MODE_STOPPED && req_word.button_one_level) begin
                  if (hold_next >= {1'b0, hold_limit_ff}) begin
                     // long hold while stopped clears everything
                     mode_in    = MODE_RESET;
                     elapsed_in = '0;
                     pos_in     = '0;
                     last_in    = '0;
                  end else begin
                     hold_in = hold_next[HOLD_W-1:0];
                  end
               end
            end
            OP_BTN_ONE: begin
               case (mode_ff)
                  MODE_RUNNING: begin
                     if (pos_ff < POS_FULL) begin
                        wr_en      = 1'b1;
                        pos_in     = pos_ff + POS_ONE;
                        changed_in = 1'b1;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  MODE_RESET: begin
                     mode_in    = MODE_RUNNING;
                     elapsed_in = '0;
                     hold_in    = '0;
                  end
                  MODE_STOPPED: begin
                     if (pos_ff > POS_ONE) begin
                        pos_in     = pos_ff - POS_ONE;
                        changed_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            OP_BTN_TWO: begin
               if (mode_ff == MODE_RUNNING) begin
                  mode_in = MODE_STOPPED;
                  last_in = (pos_ff != '0) ? IDX_W'(pos_ff - POS_ONE) : '0;
                  hold_in = '0;
               end else if (mode_ff == MODE_STOPPED) begin
                  if (pos_ff != '0 && pos_ff <= POS_W'(last_ff)) begin
                     pos_in     = pos_ff + POS_ONE;
                     changed_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // a new lap is shown straight from the write data
   always_comb begin
      if (wr_en) begin
         src_in = SRC_FWD;
      end else if (pos_in == '0) begin
         src_in = SRC_ZERO;
      end else begin
         src_in = SRC_MEM;
      end
   end

   assign rd_en   = accept && src_in == SRC_MEM;
   assign rd_addr = IDX_W'(pos_in - POS_ONE);

   slr_lap_mem #(
      .DEPTH  (LAP_DEPTH),
      .WIDTH  (TIME_WIDTH),
      .ADDR_W (IDX_W)
   ) u_lap_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[IDX_W-1:0]),
      .wr_data (elapsed_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         elapsed_ff <= '0;
         pos_ff     <= '0;
         last_ff    <= '0;
         hold_ff    <= '0;
      end else begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         pos_ff     <= pos_in;
         last_ff    <= last_in;
         hold_ff    <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff     <= src_in;
         s1_lap_ff     <= elapsed_ff;
         s1_mode_ff    <= mode_in;
         s1_elapsed_ff <= elapsed_in;
         s1_pos_ff     <= pos_in;
         s1_changed_ff <= changed_in;
         s1_full_ff    <= full_in;
      end
   end

   always_comb begin
      case (s1_src_ff)
         SRC_MEM: shown_ms = MS_W'(rd_data);
         SRC_FWD: shown_ms = MS_W'(s1_lap_ff);
         default: shown_ms = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_word_ff.mode         <= s1_mode_ff;
         rsp_word_ff.elapsed_ms   <= MS_W'(s1_elapsed_ff);
         rsp_word_ff.shown_place  <= PLACE_W'(s1_pos_ff);
         rsp_word_ff.shown_lap_ms <= shown_ms;
         rsp_word_ff.view_changed <= s1_changed_ff;
         rsp_word_ff.laps_full    <= s1_full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // csr port
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_limit_ff <= HOLD_LIMIT_RESET;
      end else if (csr_write && csr_paddr[2] == REG_HOLD_LIMIT) begin
         hold_limit_ff <= csr_pwdata[HOLD_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HOLD_LIMIT) ? CSR_DATA_W'(hold_limit_ff) : '0;

endmodule

`default_nettype wire
